[rtl/core/gtc_pkg.sv]
// shared types, constants and helpers of the gesture template classifier
package gtc_pkg;

    // class store size and derived widths
    localparam int NUM_CLASSES = 27;
    localparam int CLS_AW      = $clog2(NUM_CLASSES);
    localparam int CNT_W       = $clog2(NUM_CLASSES + 1);

    // field widths
    localparam int OP_W     = 2;
    localparam int ENTRY_W  = 6;
    localparam int FLEX_W   = 11;
    localparam int ANGLE_W  = 12;
    localparam int DIST_W   = 36;
    localparam int MASK_W   = 27;
    localparam int STATUS_W = 2;
    localparam int FW_W     = 8;
    localparam int AW_W     = 16;
    localparam int JIT_W    = 12;
    localparam int CFG_AW   = 2;

    // trained flags cover both the class count and the reported mask
    localparam int FLAGS_W = (NUM_CLASSES > MASK_W) ? NUM_CLASSES : MASK_W;

    // one template word: five flex values, pitch, roll
    localparam int NUM_FLEX = 5;
    localparam int TPL_W    = NUM_FLEX * FLEX_W + 2 * ANGLE_W;

    // datapath widths
    localparam int FSQ_W   = 2 * FLEX_W - 1;     // square of |d| <= 1024
    localparam int ASQ_W   = 2 * ANGLE_W;        // square of |d| <= 4095
    localparam int FSUM_W  = FSQ_W + 3;          // five flex squares
    localparam int ASUM_W  = ASQ_W + 1;          // two angle squares
    localparam int FPROD_W = FSUM_W + FW_W;
    localparam int APROD_W = ASUM_W + AW_W;
    localparam int TOT_W   = APROD_W + 1;

    localparam logic [FLEX_W-1:0] FLEX_FULL = FLEX_W'(1024);
    localparam logic [DIST_W-1:0] DIST_MAX  = '1;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLASSIFY  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE     = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_MATCH    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_JITTER   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_FLEX_WEIGHT  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_ANGLE_WEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_ACCEPT_LIMIT = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_JITTER_LIMIT = 2'd3;

    // configuration reset values
    localparam logic [FW_W-1:0]   FLEX_WEIGHT_RST  = 8'd5;
    localparam logic [AW_W-1:0]   ANGLE_WEIGHT_RST = 16'd157;
    localparam logic [DIST_W-1:0] ACCEPT_LIMIT_RST = 36'd8388608;
    localparam logic [JIT_W-1:0]  JITTER_LIMIT_RST = 12'd150;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [ENTRY_W-1:0]        entry;
        logic [FLEX_W-1:0]         flex_a;
        logic [FLEX_W-1:0]         flex_b;
        logic [FLEX_W-1:0]         flex_c;
        logic [FLEX_W-1:0]         flex_d;
        logic [FLEX_W-1:0]         flex_e;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] roll_angle;
    } gtc_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  class_index;
        logic [DIST_W-1:0]   best_distance;
        logic [MASK_W-1:0]   trained_mask;
    } gtc_result_t;

    // clamp a flex value to fully bent
    function automatic logic [FLEX_W-1:0] sat_flex(input logic [FLEX_W-1:0] x);
        return (x > FLEX_FULL) ? FLEX_FULL : x;
    endfunction

endpackage

[rtl/core/gtc_ram.sv]
// generic single write port ram with registered read
module gtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/gesture_template_classifier.sv]
// Gesture template classifier: nearest template search over a class store.
//
// Usage: present an item on cmd and raise start; it is taken at a rising edge
// where start is high and busy is low. Every item yields exactly one result on
// result, marked by done for a single cycle; the receiver cannot stall, so it
// must take the transfer in that cycle.
// Write template, clear entry and clear all finish at once: done rises in
// the cycle after the transfer and busy never goes high. A classify that fails
// the jitter check also answers in the next cycle.
// A classify that passes walks all NUM_CLASSES templates through one pipelined
// distance unit fed by the template ram read port, one template per cycle,
// followed by four pipeline stages and the finish state, which registers done;
// busy is high until the cycle in which done is shown.
// The user writes the configuration registers (cfg_we/cfg_addr/cfg_wdata) only
// while busy is low; the block does not enforce it. Reset restores the register
// defaults, clears all trained flags, previous pitch and roll; templates stay.
module gesture_template_classifier
    import gtc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  gtc_cmd_t            cmd,
    output logic                done,
    output gtc_result_t         result,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [DIST_W-1:0]   cfg_wdata
);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RUN    = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;

    // configuration
    logic [FW_W-1:0]   flex_weight_reg;
    logic [AW_W-1:0]   angle_weight_reg;
    logic [DIST_W-1:0] accept_limit_reg;
    logic [JIT_W-1:0]  jitter_limit_reg;

    // block state
    logic [FLAGS_W-1:0]        flags_reg, flags_next;
    logic signed [ANGLE_W-1:0] prev_pitch_reg, prev_pitch_next;
    logic signed [ANGLE_W-1:0] prev_roll_reg, prev_roll_next;

    // running best
    logic              found_reg, found_next;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic [CLS_AW-1:0] best_k_reg, best_k_next;

    // output register
    logic        done_reg, done_next;
    gtc_result_t result_reg, result_next;

    // latched feature vector
    logic [FLEX_W-1:0]         feat_flex_reg [NUM_FLEX];
    logic signed [ANGLE_W-1:0] feat_pitch_reg;
    logic signed [ANGLE_W-1:0] feat_roll_reg;

    // distance pipeline
    logic              a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic [CLS_AW-1:0] k_a_reg, k_b_reg, k_c_reg, k_d_reg;
    logic [FSQ_W-1:0]  sq_flex_reg [NUM_FLEX];
    logic [ASQ_W-1:0]  sq_pitch_reg, sq_roll_reg;
    logic [FSUM_W-1:0] flex_sum_reg;
    logic [ASUM_W-1:0] angle_sum_reg;
    logic [FPROD_W-1:0] flex_prod_reg;
    logic [APROD_W-1:0] angle_prod_reg;

    // combinational helpers
    logic                accept, is_classify, entry_ok, jitter_hit, issuing;
    logic [ANGLE_W:0]    jp_diff, jr_diff, jp_abs, jr_abs;
    logic [FSQ_W-1:0]    sq_flex_next [NUM_FLEX];
    logic [ASQ_W-1:0]    sq_pitch_next, sq_roll_next;
    logic [FSUM_W-1:0]   flex_sum_next;
    logic [TOT_W-1:0]    total;
    logic [DIST_W-1:0]   dist_sat;
    logic                cand_better, last_cand;
    logic [MASK_W-1:0]   mask_next;

    // template ram
    logic [TPL_W-1:0]  ram_wdata, ram_rdata;
    logic              ram_we;
    logic [FLEX_W-1:0] tpl_flex [NUM_FLEX];
    logic signed [ANGLE_W-1:0] tpl_pitch, tpl_roll;

    assign accept      = start && !busy;
    assign is_classify = (cmd.op == OP_CLASSIFY);
    assign entry_ok    = {1'b0, cmd.entry} < (ENTRY_W + 1)'(NUM_CLASSES);
    assign issuing     = (state_reg == S_RUN) && (issue_cnt_reg < CNT_W'(NUM_CLASSES));

    // jitter against the previous classify
    always_comb
    begin
        jp_diff = {cmd.pitch_angle[ANGLE_W-1], cmd.pitch_angle}
                - {prev_pitch_reg[ANGLE_W-1], prev_pitch_reg};
        jr_diff = {cmd.roll_angle[ANGLE_W-1], cmd.roll_angle}
                - {prev_roll_reg[ANGLE_W-1], prev_roll_reg};
        jp_abs  = jp_diff[ANGLE_W] ? (ANGLE_W + 1)'(-jp_diff) : jp_diff;
        jr_abs  = jr_diff[ANGLE_W] ? (ANGLE_W + 1)'(-jr_diff) : jr_diff;
        jitter_hit = (jp_abs > {1'b0, jitter_limit_reg})
                  || (jr_abs > {1'b0, jitter_limit_reg});
    end

    // template store
    assign ram_we    = accept && (cmd.op == OP_WRITE) && entry_ok;
    assign ram_wdata = {sat_flex(cmd.flex_a), sat_flex(cmd.flex_b), sat_flex(cmd.flex_c),
                        sat_flex(cmd.flex_d), sat_flex(cmd.flex_e),
                        cmd.pitch_angle, cmd.roll_angle};

    gtc_ram #(
        .WIDTH (TPL_W),
        .DEPTH (NUM_CLASSES)
    ) u_tpl_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd.entry[CLS_AW-1:0]),
        .wdata (ram_wdata),
        .raddr (issue_cnt_reg[CLS_AW-1:0]),
        .rdata (ram_rdata)
    );

    // unpack template word and form squared differences
    always_comb
    begin
        logic signed [FLEX_W:0]  fd;
        logic [FLEX_W-1:0]       fa;
        logic signed [ANGLE_W:0] ad;
        logic [ANGLE_W-1:0]      aa;
        for (int i = 0; i < NUM_FLEX; i++)
        begin
            tpl_flex[i]     = ram_rdata[TPL_W-1-i*FLEX_W -: FLEX_W];
            fd              = $signed({1'b0, feat_flex_reg[i]}) - $signed({1'b0, tpl_flex[i]});
            fa              = fd[FLEX_W] ? FLEX_W'(-fd) : fd[FLEX_W-1:0];
            sq_flex_next[i] = FSQ_W'(FSQ_W'(fa) * FSQ_W'(fa));
        end
        tpl_pitch     = ram_rdata[2*ANGLE_W-1 -: ANGLE_W];
        tpl_roll      = ram_rdata[ANGLE_W-1:0];
        ad            = (ANGLE_W + 1)'(feat_pitch_reg) - (ANGLE_W + 1)'(tpl_pitch);
        aa            = ad[ANGLE_W] ? ANGLE_W'(-ad) : ad[ANGLE_W-1:0];
        sq_pitch_next = ASQ_W'(aa) * ASQ_W'(aa);
        ad            = (ANGLE_W + 1)'(feat_roll_reg) - (ANGLE_W + 1)'(tpl_roll);
        aa            = ad[ANGLE_W] ? ANGLE_W'(-ad) : ad[ANGLE_W-1:0];
        sq_roll_next  = ASQ_W'(aa) * ASQ_W'(aa);
    end

    // flex square sum
    always_comb
    begin
        flex_sum_next = '0;
        for (int i = 0; i < NUM_FLEX; i++)
        begin
            flex_sum_next = flex_sum_next + FSUM_W'(sq_flex_reg[i]);
        end
    end

    // final add, saturation and compare against the running best
    always_comb
    begin
        total       = TOT_W'(flex_prod_reg) + TOT_W'(angle_prod_reg);
        dist_sat    = (total[TOT_W-1:DIST_W] != '0) ? DIST_MAX : total[DIST_W-1:0];
        cand_better = d_valid_reg && flags_reg[k_d_reg]
                   && (!found_reg || (dist_sat < best_dist_reg));
        last_cand   = d_valid_reg && (k_d_reg == CLS_AW'(NUM_CLASSES - 1));
    end

    // sequencer and block state
    always_comb
    begin
        state_next      = state_reg;
        issue_cnt_next  = issue_cnt_reg;
        flags_next      = flags_reg;
        prev_pitch_next = prev_pitch_reg;
        prev_roll_next  = prev_roll_reg;
        found_next      = found_reg;
        best_dist_next  = best_dist_reg;
        best_k_next     = best_k_reg;
        done_next       = 1'b0;
        result_next     = result_reg;

        // best update from the last pipeline stage
        if (cand_better)
        begin
            found_next     = 1'b1;
            best_dist_next = dist_sat;
            best_k_next    = k_d_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    unique case (cmd.op)
                        OP_CLASSIFY:
                        begin
                            prev_pitch_next = cmd.pitch_angle;
                            prev_roll_next  = cmd.roll_angle;
                            if (!jitter_hit)
                            begin
                                done_next      = 1'b0;
                                state_next     = S_RUN;
                                issue_cnt_next = '0;
                                found_next     = 1'b0;
                                best_dist_next = DIST_MAX;
                                best_k_next    = '0;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (entry_ok)
                            begin
                                flags_next[cmd.entry[CLS_AW-1:0]] = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (entry_ok)
                            begin
                                flags_next[cmd.entry[CLS_AW-1:0]] = 1'b0;
                            end
                        end
                        OP_CLEAR_ALL:
                        begin
                            flags_next = '0;
                        end
                        default:
                        begin
                            flags_next = flags_reg;
                        end
                    endcase
                    result_next.status        = is_classify ? ST_JITTER : ST_DONE;
                    result_next.class_index   = '0;
                    result_next.best_distance = '0;
                end
            end
            S_RUN:
            begin
                if (issuing)
                begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (last_cand)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                done_next                 = 1'b1;
                result_next.class_index   = ENTRY_W'(best_k_reg);
                result_next.best_distance = best_dist_reg;
                result_next.status        = (found_reg && (best_dist_reg <= accept_limit_reg))
                                          ? ST_MATCH : ST_NO_MATCH;
                state_next                = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        mask_next                = flags_next[MASK_W-1:0];
        result_next.trained_mask = mask_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            issue_cnt_reg    <= '0;
            flags_reg        <= '0;
            prev_pitch_reg   <= '0;
            prev_roll_reg    <= '0;
            found_reg        <= 1'b0;
            done_reg         <= 1'b0;
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            c_valid_reg      <= 1'b0;
            d_valid_reg      <= 1'b0;
            flex_weight_reg  <= FLEX_WEIGHT_RST;
            angle_weight_reg <= ANGLE_WEIGHT_RST;
            accept_limit_reg <= ACCEPT_LIMIT_RST;
            jitter_limit_reg <= JITTER_LIMIT_RST;
        end
        else
        begin
            state_reg      <= state_next;
            issue_cnt_reg  <= issue_cnt_next;
            flags_reg      <= flags_next;
            prev_pitch_reg <= prev_pitch_next;
            prev_roll_reg  <= prev_roll_next;
            found_reg      <= found_next;
            done_reg       <= done_next;
            a_valid_reg    <= issuing;
            b_valid_reg    <= a_valid_reg;
            c_valid_reg    <= b_valid_reg;
            d_valid_reg    <= c_valid_reg;
            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_FLEX_WEIGHT:  flex_weight_reg  <= cfg_wdata[FW_W-1:0];
                    CFG_ANGLE_WEIGHT: angle_weight_reg <= cfg_wdata[AW_W-1:0];
                    CFG_ACCEPT_LIMIT: accept_limit_reg <= cfg_wdata;
                    CFG_JITTER_LIMIT: jitter_limit_reg <= cfg_wdata[JIT_W-1:0];
                    default:          flex_weight_reg  <= flex_weight_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        best_dist_reg <= best_dist_next;
        best_k_reg    <= best_k_next;
        if (done_next)
        begin
            result_reg <= result_next;
        end
        // feature latch on a classify transfer
        if (accept && is_classify)
        begin
            feat_flex_reg[0] <= sat_flex(cmd.flex_a);
            feat_flex_reg[1] <= sat_flex(cmd.flex_b);
            feat_flex_reg[2] <= sat_flex(cmd.flex_c);
            feat_flex_reg[3] <= sat_flex(cmd.flex_d);
            feat_flex_reg[4] <= sat_flex(cmd.flex_e);
            feat_pitch_reg   <= cmd.pitch_angle;
            feat_roll_reg    <= cmd.roll_angle;
        end
        // distance pipeline
        k_a_reg        <= issue_cnt_reg[CLS_AW-1:0];
        k_b_reg        <= k_a_reg;
        k_c_reg        <= k_b_reg;
        k_d_reg        <= k_c_reg;
        sq_flex_reg    <= sq_flex_next;
        sq_pitch_reg   <= sq_pitch_next;
        sq_roll_reg    <= sq_roll_next;
        flex_sum_reg   <= flex_sum_next;
        angle_sum_reg  <= ASUM_W'(sq_pitch_reg) + ASUM_W'(sq_roll_reg);
        flex_prod_reg  <= FPROD_W'(flex_sum_reg) * FPROD_W'(flex_weight_reg);
        angle_prod_reg <= APROD_W'(angle_sum_reg) * APROD_W'(angle_weight_reg);
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // a matched result stays within the acceptance limit
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_MATCH) |-> result.best_distance <= accept_limit_reg)
        else $error("match reported above acceptance limit");

    // a matched class is a trained one
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_MATCH) |-> flags_reg[result.class_index[CLS_AW-1:0]])
        else $error("match reported on untrained class");

    // commands answer in the next cycle with done status
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.op != OP_CLASSIFY) |=> done && (result.status == ST_DONE))
        else $error("command did not complete in one cycle");

    // distance pipeline only runs during a search
    assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg |-> (state_reg == S_RUN))
        else $error("distance pipeline active outside a search");

    // the search ends right after the last template leaves the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) && last_cand |=> (state_reg == S_FINISH) && !done)
        else $error("search did not finish after last template");

endmodule
